// ----- hw/rtl/four_level_page_table_manager_assert.svh -----
// Assertion macros for the page table manager RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PGT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PGT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pgtbl_pkg.sv -----
// Types and constants of the page table manager.
`default_nettype none

package pgtbl_pkg;

	localparam int unsigned TABLE_PAGES_DFLT  = 64;
	localparam int unsigned ENTRIES_PER_TABLE = 512;
	localparam int unsigned IDX_W             = 9;
	localparam int unsigned VA_W              = 48;
	localparam int unsigned PA_W              = 52;
	localparam int unsigned PG_W              = 40;   // page number bits of a 52-bit address
	localparam int unsigned ENTRY_W           = 64;

	localparam logic [11:0] LINK_FLAGS = 12'h007;

	typedef enum logic [1:0] {
		OP_MAP    = 2'd0,
		OP_UNMAP  = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_MISALIGN = 2'd1,
		STAT_ABSENT   = 2'd2,
		STAT_NO_PAGES = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_CLR,
		S_DONE
	} pgtbl_state_t;

	typedef struct packed {
		status_t           status;
		logic [PA_W-1:0]   translated_addr;
		logic              tlb_invalidate;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pgtbl_if.sv -----
// Request and response channel interfaces of the page table manager.
`default_nettype none

interface pgtbl_req_if import pgtbl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [VA_W-1:0]      virt_addr;
	logic [PA_W-1:0]      phys_addr;
	logic [ENTRY_W-1:0]   entry_flags;

	modport source (output valid, opcode, virt_addr, phys_addr, entry_flags, input ready);
	modport sink   (input valid, opcode, virt_addr, phys_addr, entry_flags, output ready);
endinterface

interface pgtbl_rsp_if import pgtbl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [PA_W-1:0]      translated_addr;
	logic                 tlb_invalidate;

	modport source (output valid, status, translated_addr, tlb_invalidate, input ready);
	modport sink   (input valid, status, translated_addr, tlb_invalidate, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pgtbl_mem.sv -----
// Table memory: one write port, one read port with registered read data.
`default_nettype none

module pgtbl_mem import pgtbl_pkg::*; #(
	parameter int unsigned TABLE_PAGES = TABLE_PAGES_DFLT,
	localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE,
	localparam int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [ENTRY_W-1:0] wdata,
	input  wire logic               re,
	input  wire logic [AW-1:0]      raddr,
	output      logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pgtbl_walk.sv -----
// Walk sequencer: decodes operations, walks levels, allocates and clears tables.
`default_nettype none

module pgtbl_walk import pgtbl_pkg::*; #(
	parameter int unsigned TABLE_PAGES = TABLE_PAGES_DFLT,
	localparam int unsigned PW = $clog2(TABLE_PAGES),
	localparam int unsigned NW = $clog2(TABLE_PAGES + 1),
	localparam int unsigned AW = PW + IDX_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	pgtbl_req_if.sink               req,
	input  wire logic               cfg_we,
	input  wire logic [PA_W-1:0]    cfg_wdata,
	output      logic               mem_we,
	output      logic [AW-1:0]      mem_waddr,
	output      logic [ENTRY_W-1:0] mem_wdata,
	output      logic               mem_re,
	output      logic [AW-1:0]      mem_raddr,
	input  wire logic [ENTRY_W-1:0] mem_rdata,
	output      logic               res_valid,
	input  wire logic               res_ready,
	output      res_t               res
);

	pgtbl_state_t state_q, state_d;

	logic [1:0]          lvl_q;
	logic [PW-1:0]       cur_q;
	logic [NW-1:0]       nfp_q;
	logic [IDX_W-1:0]    cnt_q;
	logic                init_q;
	logic [PA_W-1:0]     base_q;

	logic [1:0]          op_q;
	logic [VA_W-1:0]     va_q;
	logic [PG_W-1:0]     pa_pg_q;
	logic [ENTRY_W-1:0]  fl_q;
	res_t                res_q;

	logic                accept;
	logic                pre_fail;
	status_t             pre_stat;

	logic [IDX_W-1:0]    idx;
	logic                is_leaf;
	logic                leaf_wr;
	logic                cnt_end;
	logic                can_alloc;
	logic [PG_W:0]       diff;
	logic                follow_ok;
	logic [PW-1:0]       next_pg;
	logic [PG_W-1:0]     link_pg;
	logic [ENTRY_W-1:0]  leaf_val;

	logic                ev_done;
	logic                ev_alloc;
	status_t             ev_stat;
	logic [PA_W-1:0]     ev_addr;

	assign accept = req.valid && req.ready;

	// Alignment and opcode checks done straight off the request.
	always_comb begin
		pre_fail = 1'b0;
		pre_stat = STAT_OK;
		case (req.opcode)
			OP_MAP: begin
				if (req.virt_addr[11:0] != 12'd0 || req.phys_addr[11:0] != 12'd0) begin
					pre_fail = 1'b1;
					pre_stat = STAT_MISALIGN;
				end
			end
			OP_UNMAP: begin
				if (req.virt_addr[11:0] != 12'd0) begin
					pre_fail = 1'b1;
					pre_stat = STAT_MISALIGN;
				end
			end
			OP_LOOKUP: begin
				pre_fail = 1'b0;
			end
			default: begin
				pre_fail = 1'b1;
				pre_stat = STAT_ABSENT;
			end
		endcase
	end

	always_comb begin
		unique case (lvl_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			2'd2:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	assign is_leaf   = (lvl_q == 2'd3);
	assign leaf_wr   = is_leaf && (op_q != OP_LOOKUP);
	assign cnt_end   = (cnt_q == IDX_W'(ENTRIES_PER_TABLE - 1));
	assign can_alloc = (nfp_q < NW'(TABLE_PAGES));
	assign leaf_val  = (op_q == OP_MAP) ? ({12'd0, pa_pg_q, 12'd0} | fl_q | 64'd1) : '0;
	assign link_pg   = base_q[51:12] + PG_W'(nfp_q);

	// Pointer check: present, inside the table area, at an allocated page.
	assign diff      = {1'b0, mem_rdata[51:12]} - {1'b0, base_q[51:12]};
	assign follow_ok = mem_rdata[0] && !diff[PG_W] && (diff[PG_W-1:NW] == '0)
		&& (diff[NW-1:0] < nfp_q);
	assign next_pg   = diff[PW-1:0];

	always_comb begin
		ev_done  = 1'b0;
		ev_alloc = 1'b0;
		ev_stat  = STAT_OK;
		ev_addr  = '0;
		if (op_q == OP_LOOKUP && is_leaf) begin
			ev_done = 1'b1;
			if (mem_rdata[0]) begin
				ev_addr = {mem_rdata[51:12], va_q[11:0]};
			end else begin
				ev_stat = STAT_ABSENT;
			end
		end else if (op_q == OP_LOOKUP && lvl_q == 2'd2 && mem_rdata[0] && mem_rdata[7]) begin
			// 2 MiB page at the directory level
			ev_done = 1'b1;
			ev_addr = {mem_rdata[51:21], va_q[20:0]};
		end else if (op_q == OP_MAP && !mem_rdata[0]) begin
			if (can_alloc) begin
				ev_alloc = 1'b1;
			end else begin
				ev_done = 1'b1;
				ev_stat = STAT_NO_PAGES;
			end
		end else if (!follow_ok) begin
			ev_done = 1'b1;
			ev_stat = STAT_ABSENT;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = pre_fail ? S_DONE : S_RD;
				end
			end
			S_RD: begin
				state_d = leaf_wr ? S_DONE : S_EV;
			end
			S_EV: begin
				if (ev_done) begin
					state_d = S_DONE;
				end else if (ev_alloc) begin
					state_d = S_CLR;
				end else begin
					state_d = S_RD;
				end
			end
			S_CLR: begin
				if (cnt_end) begin
					state_d = init_q ? S_IDLE : S_RD;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = {cur_q, idx};
		mem_we    = 1'b0;
		mem_waddr = {cur_q, idx};
		mem_wdata = '0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_RD: begin
				if (leaf_wr) begin
					mem_we    = 1'b1;
					mem_wdata = leaf_val;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_EV: begin
				if (ev_alloc) begin
					mem_we    = 1'b1;
					mem_wdata = {12'd0, link_pg, LINK_FLAGS};
				end
			end
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {cur_q, cnt_q};
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;   // root page sweep after reset
			init_q  <= 1'b1;
			lvl_q   <= '0;
			cur_q   <= '0;
			cnt_q   <= '0;
			nfp_q   <= NW'(1);
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lvl_q <= '0;
						cur_q <= '0;
					end
				end
				S_EV: begin
					if (ev_alloc) begin
						cur_q <= nfp_q[PW-1:0];
						nfp_q <= nfp_q + NW'(1);
						lvl_q <= lvl_q + 2'd1;
						cnt_q <= '0;
					end else if (!ev_done) begin
						cur_q <= next_pg;
						lvl_q <= lvl_q + 2'd1;
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_end) begin
						init_q <= 1'b0;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			op_q    <= req.opcode;
			va_q    <= req.virt_addr;
			pa_pg_q <= req.phys_addr[51:12];
			fl_q    <= req.entry_flags;
			res_q   <= '{status: pre_stat, translated_addr: '0, tlb_invalidate: 1'b0};
		end else if (state_q == S_RD && leaf_wr) begin
			res_q   <= '{status: STAT_OK, translated_addr: '0, tlb_invalidate: 1'b1};
		end else if (state_q == S_EV && ev_done) begin
			res_q   <= '{status: ev_stat, translated_addr: ev_addr, tlb_invalidate: 1'b0};
		end
	end

`include "four_level_page_table_manager_assert.svh"

	`PGT_ASSERT_NOW(a_nfp_bound, 1'b1, nfp_q <= NW'(TABLE_PAGES), "page counter past table area")
	`PGT_ASSERT_NOW(a_no_rw_clash, mem_we, !mem_re, "table read and write in one cycle")
	`PGT_ASSERT_NOW(a_inv_ok, res_valid && res.tlb_invalidate, res.status == STAT_OK,
		"invalidate flagged on a failed operation")
	`PGT_ASSERT_NOW(a_ev_after_rd, state_q == S_EV, $past(state_q) == S_RD,
		"evaluation without a table read")
	`PGT_ASSERT_NOW(a_init_blocks, init_q, !req.ready, "request taken during root sweep")

endmodule

`default_nettype wire

// ----- hw/rtl/four_level_page_table_manager.sv -----
// Top level of the four-level page table manager.
//
//   channel  dir  transfer                         payload
//   req      in   req.valid & req.ready            opcode, virt_addr, phys_addr, entry_flags
//   rsp      out  rsp.valid & rsp.ready            status, translated_addr, tlb_invalidate
//   cfg      in   cfg_we (no handshake)            cfg_wdata = table_area_base
//
// A rejected request goes to its result without a table read. Each table level takes
// one read and one check; map and unmap write the leaf entry without reading it, and a
// 2 MiB lookup stops at the directory level; a walk stops early when a level is missing.
// Map clears each table page that it allocates before it walks on.
// After reset the root page is swept clean before req.ready rises.
// The result sits in an output register; the walker holds its result until that
// register is free, and a new request is taken while a result waits downstream.
`default_nettype none

module four_level_page_table_manager import pgtbl_pkg::*; #(
	parameter int unsigned TABLE_PAGES = TABLE_PAGES_DFLT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	pgtbl_req_if.sink            req,
	pgtbl_rsp_if.source          rsp,
	input  wire logic            cfg_we,
	input  wire logic [PA_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(TABLE_PAGES) + IDX_W;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	logic               res_valid;
	logic               res_ready;
	res_t               res;

	logic               rsp_valid_q;
	res_t               rsp_q;

	pgtbl_mem #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pgtbl_walk #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.translated_addr = rsp_q.translated_addr;
	assign rsp.tlb_invalidate  = rsp_q.tlb_invalidate;

endmodule

`default_nettype wire

// ----- bench/tb_four_level_page_table_manager.sv -----
// Testbench of the page table manager: directed walks, then random traffic against a table model.
module tb_four_level_page_table_manager;
	timeunit 1ns;
	timeprecision 1ps;
	import pgtbl_pkg::*;

	localparam int unsigned PAGES = TABLE_PAGES_DFLT;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [PA_W-1:0] PAGE_MASK = 52'hF_FFFF_FFFF_F000;
	localparam logic [ENTRY_W-1:0] LINK_BITS = {52'h0, LINK_FLAGS};
	localparam logic [ENTRY_W-1:0] PRESENT_BIT = 64'h1;

	// addresses the directed walks are built around
	localparam logic [VA_W-1:0] VA_DEEP = 48'h0080_8060_5000;	// indexes 1, 2, 3, 5
	localparam logic [VA_W-1:0] VA_SIDE = 48'h0100_0000_0000;	// root index 2
	localparam logic [VA_W-1:0] VA_TOP  = 48'hFFFF_FFFF_F000;

	typedef enum logic {ROW_XFER, ROW_BASE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [1:0]           op;
		logic [VA_W-1:0]      va;
		logic [PA_W-1:0]      pa;	// base value on ROW_BASE rows
		logic [ENTRY_W-1:0]   fl;
		logic                 fixed;
		res_t                 want;
	} row_t;

	localparam res_t MODEL  = '0;
	localparam res_t ABSENT = '{STAT_ABSENT, 52'h0, 1'b0};
	localparam res_t BADALN = '{STAT_MISALIGN, 52'h0, 1'b0};

	localparam row_t ROWS [24] = '{
		'{ROW_XFER, OP_LOOKUP, 48'h0, 52'h0, 64'h0, 1'b1, ABSENT},
		'{ROW_XFER, OP_UNMAP, 48'h0, 52'h0, 64'h0, 1'b1, ABSENT},
		'{ROW_XFER, OP_UNUSED, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, '1, 1'b1, ABSENT},
		'{ROW_XFER, OP_MAP, 48'h0000_0000_0123, 52'h0, 64'h0, 1'b1, BADALN},
		'{ROW_XFER, OP_MAP, 48'h0, 52'h0_0000_0000_0FFF, 64'h0, 1'b1, BADALN},
		'{ROW_XFER, OP_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, 1'b1, BADALN},
		'{ROW_XFER, OP_MAP, VA_DEEP, 52'h0_0123_4560_0000, 64'h80, 1'b0, MODEL},
		'{ROW_XFER, OP_MAP, VA_SIDE, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_MAP, VA_TOP, 52'hF_FFFF_FFFF_F000, '1, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, 1'b1,
			'{STAT_OK, 52'hF_FFFF_FFFF_FFFF, 1'b0}},
		'{ROW_XFER, OP_LOOKUP, 48'h0080_8060_5ABC, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, 48'h0080_8060_6000, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_UNMAP, 48'h0080_8060_6000, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_UNMAP, VA_DEEP, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, VA_DEEP, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_MAP, VA_DEEP, 52'h0_0123_4560_0000, 64'h80, 1'b0, MODEL},
		// shift the area by one page: root entry 1 now points back at the root, whose
		// entry 2 (the VA_SIDE link) lands on the leaf table of VA_DEEP; its entry 5
		// carries bit 7, so the lookup ends as a huge page
		'{ROW_BASE, OP_MAP, 48'h0, 52'h0_0000_0000_1000, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, 48'h0080_80BA_BCDE, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_MAP, 48'h0080_C000_0000, 52'h0_0000_ABCD_E000, 64'h6, 1'b0, MODEL},
		// the root link of VA_DEEP now points below the area
		'{ROW_BASE, OP_MAP, 48'h0, 52'h0_0000_0000_2FFF, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, VA_DEEP, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_MAP, VA_DEEP, 52'h0_0000_0000_1000, 64'h0, 1'b0, MODEL},
		'{ROW_BASE, OP_MAP, 48'h0, 52'h0, 64'h0, 1'b0, MODEL},
		'{ROW_XFER, OP_LOOKUP, 48'h0080_8060_5ABC, 52'h0, 64'h0, 1'b0, MODEL}
	};

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [PA_W-1:0] cfg_wdata;

	pgtbl_req_if req_ch ();
	pgtbl_rsp_if rsp_ch ();

	four_level_page_table_manager #(.TABLE_PAGES(PAGES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// table model state
	logic [ENTRY_W-1:0] pt_mem [PAGES*ENTRIES_PER_TABLE];
	int unsigned        alloc_next;
	logic [PA_W-1:0]    area_base;

	res_t        pending_q [$];
	int unsigned mismatches;
	int unsigned op_count [4];
	int unsigned status_count [4];
	int unsigned base_writes;
	bit          calm;
	logic [26:0] regions [6];

	function automatic int unsigned slot(input int unsigned page, input logic [8:0] idx);
		return page * ENTRIES_PER_TABLE + idx;
	endfunction

	// Resolve a link to a table page; fails when absent, below the area or unallocated.
	function automatic bit link_target(input logic [ENTRY_W-1:0] e, output int unsigned pg);
		logic [PA_W-1:0] org;
		logic [PA_W-1:0] addr;
		logic [PA_W-1:0] span;
		org = area_base & PAGE_MASK;
		addr = e[PA_W-1:0] & PAGE_MASK;
		pg = 0;
		if (!e[0] || addr < org)
			return 1'b0;
		span = (addr - org) >> 12;
		if (span >= alloc_next || span >= PAGES)
			return 1'b0;
		pg = 32'(span);
		return 1'b1;
	endfunction

	function automatic status_t table_map(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
		input logic [ENTRY_W-1:0] fl);
		int unsigned     cur;
		int unsigned     pg;
		int              lvl;
		int unsigned     k;
		logic [8:0]      idx;
		logic [PA_W-1:0] addr;
		if (va[11:0] != 0 || pa[11:0] != 0)
			return STAT_MISALIGN;
		cur = 0;
		for (lvl = 3; lvl >= 1; lvl--) begin
			idx = va[12 + 9*lvl +: 9];
			if (pt_mem[slot(cur, idx)][0]) begin
				// bit 7 is not looked at here, the entry is taken as a link
				if (!link_target(pt_mem[slot(cur, idx)], pg))
					return STAT_ABSENT;
				cur = pg;
			end else begin
				if (alloc_next >= PAGES)
					return STAT_NO_PAGES;
				pg = alloc_next;
				alloc_next++;
				for (k = 0; k < ENTRIES_PER_TABLE; k++)
					pt_mem[pg*ENTRIES_PER_TABLE + k] = '0;
				addr = ((area_base & PAGE_MASK) + pg * 4096) & PAGE_MASK;
				pt_mem[slot(cur, idx)] = {12'h0, addr} | LINK_BITS;
				cur = pg;
			end
		end
		pt_mem[slot(cur, va[20:12])] = {12'h0, pa & PAGE_MASK} | fl | PRESENT_BIT;
		return STAT_OK;
	endfunction

	function automatic status_t table_unmap(input logic [VA_W-1:0] va);
		int unsigned cur;
		int          lvl;
		if (va[11:0] != 0)
			return STAT_MISALIGN;
		cur = 0;
		for (lvl = 3; lvl >= 1; lvl--) begin
			if (!link_target(pt_mem[slot(cur, va[12 + 9*lvl +: 9])], cur))
				return STAT_ABSENT;
		end
		// leaf present bit is not checked
		pt_mem[slot(cur, va[20:12])] = '0;
		return STAT_OK;
	endfunction

	function automatic status_t table_lookup(input logic [VA_W-1:0] va, output logic [PA_W-1:0] xl);
		int unsigned        cur;
		logic [ENTRY_W-1:0] e;
		xl = '0;
		cur = 0;
		if (!link_target(pt_mem[slot(0, va[47:39])], cur))
			return STAT_ABSENT;
		if (!link_target(pt_mem[slot(cur, va[38:30])], cur))
			return STAT_ABSENT;
		e = pt_mem[slot(cur, va[29:21])];
		if (!e[0])
			return STAT_ABSENT;
		if (e[7]) begin
			xl = {e[51:21], 21'h0} + {31'h0, va[20:0]};
			return STAT_OK;
		end
		if (!link_target(e, cur))
			return STAT_ABSENT;
		e = pt_mem[slot(cur, va[20:12])];
		if (!e[0])
			return STAT_ABSENT;
		xl = {e[51:12], va[11:0]};
		return STAT_OK;
	endfunction

	function automatic res_t walk_request(input logic [1:0] op, input logic [VA_W-1:0] va,
		input logic [PA_W-1:0] pa, input logic [ENTRY_W-1:0] fl);
		res_t            r;
		logic [PA_W-1:0] xl;
		r = '0;
		case (op)
			OP_MAP: begin
				r.status = table_map(va, pa, fl);
				r.tlb_invalidate = (r.status == STAT_OK);
			end
			OP_UNMAP: begin
				r.status = table_unmap(va);
				r.tlb_invalidate = (r.status == STAT_OK);
			end
			OP_LOOKUP: begin
				r.status = table_lookup(va, xl);
				r.translated_addr = xl;
			end
			default: r.status = STAT_ABSENT;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_ch.ready = calm || ($urandom_range(0, 99) >= 24);
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatches++;
			end else begin
				want = pending_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.translated_addr !== want.translated_addr) begin
					$error("translated_addr: expected %h, got %h", want.translated_addr,
						rsp_ch.translated_addr);
					mismatches++;
				end
				if (rsp_ch.tlb_invalidate !== want.tlb_invalidate) begin
					$error("tlb_invalidate: expected %0b, got %0b", want.tlb_invalidate,
						rsp_ch.tlb_invalidate);
					mismatches++;
				end
			end
		end
	end

	// Entered and left at a falling edge.
	task automatic issue(input logic [1:0] op, input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
		input logic [ENTRY_W-1:0] fl, input bit fixed, input res_t want);
		res_t got;
		while (!calm && $urandom_range(0, 99) < 24) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.virt_addr = va;
		req_ch.phys_addr = pa;
		req_ch.entry_flags = fl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		got = walk_request(op, va, pa, fl);
		pending_q.push_back(fixed ? want : got);
		op_count[op]++;
		status_count[got.status]++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_base(input logic [PA_W-1:0] v);
		drain_results();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		area_base = v;
		base_writes++;
	endtask

	task automatic refresh_regions();
		int i;
		for (i = 3; i < 6; i++) begin
			regions[i] = 27'($urandom);
			// half the new regions share upper tables with a fixed one
			if ($urandom_range(0, 1))
				regions[i][26:9] = regions[$urandom_range(0, 2)][26:9];
		end
	endtask

	task automatic random_phase(input logic [PA_W-1:0] base, input int unsigned items, input bit quiet,
		input int unsigned fresh_pct);
		int unsigned        n;
		int unsigned        r;
		logic [1:0]         op;
		logic [26:0]        pre;
		logic [8:0]         leaf;
		logic [11:0]        off;
		logic [PA_W-1:0]    pa;
		logic [ENTRY_W-1:0] fl;
		write_base(base);
		calm = quiet;
		for (n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				op = OP_MAP;
			else if (r < 60)
				op = OP_UNMAP;
			else if (r < 95)
				op = OP_LOOKUP;
			else
				op = OP_UNUSED;
			pre = ($urandom_range(0, 99) < fresh_pct) ? 27'($urandom) : regions[$urandom_range(0, 5)];
			leaf = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 7)) : 9'($urandom);
			off = (op == OP_LOOKUP || $urandom_range(0, 19) == 0) ? 12'($urandom) : 12'h0;
			pa = PA_W'({$urandom, $urandom});
			if ($urandom_range(0, 19) != 0)
				pa[11:0] = '0;
			fl = {$urandom, $urandom};
			if ($urandom_range(0, 1))
				fl[51:12] = '0;
			issue(op, {pre, leaf, off}, pa, fl, 1'b0, MODEL);
		end
		calm = 1'b0;
	endtask

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.virt_addr = '0;
		req_ch.phys_addr = '0;
		req_ch.entry_flags = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		base_writes = 0;
		foreach (op_count[k]) begin
			op_count[k] = 0;
			status_count[k] = 0;
		end
		foreach (pt_mem[k])
			pt_mem[k] = '0;
		alloc_next = 1;
		area_base = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < $size(ROWS); i++) begin
			if (ROWS[i].kind == ROW_BASE)
				write_base(ROWS[i].pa);
			else
				issue(ROWS[i].op, ROWS[i].va, ROWS[i].pa, ROWS[i].fl, ROWS[i].fixed, ROWS[i].want);
		end

		regions[0] = VA_DEEP[47:21];
		regions[1] = VA_SIDE[47:21];
		regions[2] = VA_TOP[47:21];
		refresh_regions();
		random_phase('0, 350, 1'b0, 3);
		refresh_regions();
		// area moved by a few pages: old links alias other tables
		random_phase({38'h0, 2'($urandom_range(1, 3)), 12'($urandom)}, 300, 1'b1, 3);
		refresh_regions();
		random_phase('1, 150, 1'b0, 3);
		// many fresh regions here, so the table pages run out
		random_phase('0, 300, 1'b0, 30);
		refresh_regions();
		random_phase({40'h0, 12'($urandom)}, 250, 1'b0, 3);

		drain_results();
		repeat (16) @(posedge clk);

		$display("covered %0d map, %0d unmap, %0d lookup, %0d bad-opcode ops, %0d bases",
			op_count[OP_MAP], op_count[OP_UNMAP], op_count[OP_LOOKUP], op_count[OP_UNUSED],
			base_writes);
		$display("%0d ok, %0d misaligned, %0d absent, %0d no pages; %0d of %0d pages used",
			status_count[STAT_OK], status_count[STAT_MISALIGN], status_count[STAT_ABSENT],
			status_count[STAT_NO_PAGES], alloc_next, PAGES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: walker stopped making progress");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
